@@ rtl/core/sss_pkg.sv @@
// sss_pkg: shared widths, codes, command/status structs and cosine table
// for the sky scan sequencer. No dependencies.

package sss_pkg;

   localparam int MAX_TARGETS_DEF = 1024;

   localparam int STEP_W   = 6;
   localparam int DWELL_W  = 16;
   localparam int TIME_W   = 32;
   localparam int AZ_W     = 16;
   localparam int EL_W     = 7;
   localparam int IDX_W    = 11;
   localparam int RING_W   = 7;
   localparam int POS_W    = 9;
   localparam int COS_W    = 17;
   localparam int MODE_W   = 2;
   localparam int EVENT_W  = 2;

   // shared divider widths
   localparam int DVD_W      = 25;
   localparam int DVS_W      = 10;
   localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

   // stream and register port widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int REG_SEL_BIT = 2;

   localparam logic [STEP_W-1:0]  STEP_RESET  = 6'd10;
   localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd5000;
   localparam logic [STEP_W-1:0]  STEP_MIN    = 6'd1;
   localparam logic [STEP_W-1:0]  STEP_MAX    = 6'd45;
   localparam int EL_TOP    = 90;
   localparam int AZ_CLAMP  = 17900;
   localparam int AZ_WRAP   = 36000;
   localparam int AZ_SCALE  = 72000;
   localparam int SIZE_SCALE = 720;
   localparam int LAST_BIAS = 180;

   // register selects (address bit 2)
   localparam logic REG_STEP  = 1'b0;
   localparam logic REG_DWELL = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2
   } mode_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_POINT   = 2'd0,
      EV_ARRIVED = 2'd1,
      EV_DONE    = 2'd2,
      EV_STOPPED = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      DIV_LAST = 2'd0,
      DIV_SIZE = 2'd1,
      DIV_AZ   = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        start_scan;
      logic        finish;
      logic        arrive;
      logic        count_inc;
      logic        adv;
      logic        last_ld;
      logic        size_ld;
      logic        az_ld;
      logic        div_go;
      div_sel_type div_sel;
      logic        emit;
      event_type   ev;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic dwelling;
      logic req_start;
      logic req_stop;
      logic req_tick;
      logic moving;
      logic expired;
      logic count_full;
      logic pos_wrap;
      logic ring_over;
      logic cand_skip;
      logic div_done;
      logic out_free;
   } sts_type;

   // round(65536*cos(d)) for whole degrees 0..89
   localparam logic [COS_W-1:0] COS_TAB [90] = '{
      17'd65536, 17'd65526, 17'd65496, 17'd65446, 17'd65376,
      17'd65287, 17'd65177, 17'd65048, 17'd64898, 17'd64729,
      17'd64540, 17'd64332, 17'd64104, 17'd63856, 17'd63589,
      17'd63303, 17'd62997, 17'd62672, 17'd62328, 17'd61966,
      17'd61584, 17'd61183, 17'd60764, 17'd60326, 17'd59870,
      17'd59396, 17'd58903, 17'd58393, 17'd57865, 17'd57319,
      17'd56756, 17'd56175, 17'd55578, 17'd54963, 17'd54332,
      17'd53684, 17'd53020, 17'd52339, 17'd51643, 17'd50931,
      17'd50203, 17'd49461, 17'd48703, 17'd47930, 17'd47143,
      17'd46341, 17'd45525, 17'd44695, 17'd43852, 17'd42995,
      17'd42126, 17'd41243, 17'd40348, 17'd39441, 17'd38521,
      17'd37590, 17'd36647, 17'd35693, 17'd34729, 17'd33754,
      17'd32768, 17'd31772, 17'd30767, 17'd29753, 17'd28729,
      17'd27697, 17'd26656, 17'd25607, 17'd24550, 17'd23486,
      17'd22415, 17'd21336, 17'd20252, 17'd19161, 17'd18064,
      17'd16962, 17'd15855, 17'd14742, 17'd13626, 17'd12505,
      17'd11380, 17'd10252, 17'd9121,  17'd7987,  17'd6850,
      17'd5712,  17'd4572,  17'd3430,  17'd2287,  17'd1144
   };

   function automatic logic [COS_W-1:0] cos_q16(input logic [EL_W-1:0] d);
      logic [COS_W-1:0] r;
      r = '0;
      if (d < EL_W'(EL_TOP)) begin
         r = COS_TAB[d];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/sky_scan_sequencer.sv @@
// sky_scan_sequencer: top level - register port, controller and datapath.
// Depends on sss_pkg, sss_ctrl, sss_dp (and sss_div below it).
//
// Usage: command beats enter on req_ (tuser = mode: tick, start, stop;
// tdata = rotator_moving, time_ms). Each accepted beat yields zero or one
// result beat on rsp_ (tuser = event, tdata = azimuth, elevation, index).
// One beat is worked at a time; req_tready is high only while the
// controller is idle.
// Stop and arrival results pass through the emit state into the result
// register; beats that cause no result leave the controller idle. Each
// pass of the shared serial divider works out 25 quotient bits. A start
// runs three passes before its point result; advancing to a target runs
// count check, advance, candidate and an azimuth pass, with ring check and
// a size pass on a new ring and advance and candidate per skipped slot.
// The result register holds one beat; if the receiver stalls, the block
// holds the next result in its emit state and takes no new beat.
// Reset clears the scan (idle, step 10, dwell 5000 ms) and drops rsp_tvalid.
// Registers: ring step at byte address 0, dwell_ms at 4; step is latched
// at scan start, dwell is used live.

module sky_scan_sequencer #(
   parameter int MAX_TARGETS = sss_pkg::MAX_TARGETS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: rotator_moving[0], time_ms[32:1], zero fill
   input  logic [sss_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: mode[1:0]
   input  logic [sss_pkg::MODE_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: target_az_centi[15:0], target elevation[22:16],
   // target_index[33:23], zero fill
   output logic [sss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: event_res[1:0]
   output logic [sss_pkg::EVENT_W-1:0]     rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sss_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [sss_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [sss_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);

   logic [sss_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [sss_pkg::DWELL_W-1:0] dwell_ff, dwell_in;
   logic                        csr_wr;
   sss_pkg::cmd_type            cmd;
   sss_pkg::sts_type            sts;
   logic signed [sss_pkg::AZ_W-1:0] az;
   logic [sss_pkg::EL_W-1:0]    el;
   logic [sss_pkg::IDX_W-1:0]   idx;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      step_in  = step_ff;
      dwell_in = dwell_ff;
      if (csr_wr) begin
         if (csr_paddr[sss_pkg::REG_SEL_BIT] == sss_pkg::REG_STEP) begin
            step_in = csr_pwdata[sss_pkg::STEP_W-1:0];
         end else begin
            dwell_in = csr_pwdata[sss_pkg::DWELL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= sss_pkg::STEP_RESET;
         dwell_ff <= sss_pkg::DWELL_RESET;
      end else begin
         step_ff  <= step_in;
         dwell_ff <= dwell_in;
      end
   end

   assign csr_prdata = (csr_paddr[sss_pkg::REG_SEL_BIT] == sss_pkg::REG_DWELL) ?
                       sss_pkg::CSR_DW'(dwell_ff) : sss_pkg::CSR_DW'(step_ff);

   sss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sss_dp #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .step_cfg        (step_ff),
      .dwell_ms        (dwell_ff),
      .mode            (req_tuser),
      .rotator_moving  (req_tdata[0]),
      .time_ms         (req_tdata[sss_pkg::TIME_W:1]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .event_res       (rsp_tuser),
      .target_az_centi (az),
      .target_el       (el),
      .target_index    (idx)
   );

   assign rsp_tdata = {6'd0, idx, el, az};

endmodule

@@ rtl/core/sss_div.sv @@
// sss_div: shared restoring divider, one quotient bit per cycle.
// Depends on sss_pkg for operand widths.

module sss_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [sss_pkg::DVD_W-1:0]   dividend,
   input  logic [sss_pkg::DVS_W-1:0]   divisor,
   output logic [sss_pkg::DVD_W-1:0]   quotient,
   output logic                        done
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [sss_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [sss_pkg::DVS_W-1:0]       rem_ff, rem_in;
   logic [sss_pkg::DVS_W-1:0]       dvs_ff, dvs_in;
   logic [sss_pkg::DVD_W-1:0]       quo_ff, quo_in;
   logic [sss_pkg::DVS_W:0]         trial;
   logic [sss_pkg::DVS_W:0]         diff;
   logic                            fits;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, quo_ff[sss_pkg::DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = sss_pkg::DIV_CNT_W'(sss_pkg::DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[sss_pkg::DVS_W-1:0] : trial[sss_pkg::DVS_W-1:0];
         quo_in = {quo_ff[sss_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == sss_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ rtl/core/sss_dp.sv @@
// sss_dp: scan datapath - scan state, target arithmetic, result register.
// Depends on sss_pkg and sss_div.

module sss_dp #(
   parameter int MAX_TARGETS = sss_pkg::MAX_TARGETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sss_pkg::cmd_type              cmd,
   output sss_pkg::sts_type              sts,
   input  logic [sss_pkg::STEP_W-1:0]    step_cfg,
   input  logic [sss_pkg::DWELL_W-1:0]   dwell_ms,
   input  logic [sss_pkg::MODE_W-1:0]    mode,
   input  logic                          rotator_moving,
   input  logic [sss_pkg::TIME_W-1:0]    time_ms,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [sss_pkg::EVENT_W-1:0]   event_res,
   output logic signed [sss_pkg::AZ_W-1:0] target_az_centi,
   output logic [sss_pkg::EL_W-1:0]      target_el,
   output logic [sss_pkg::IDX_W-1:0]     target_index
);

   localparam int CNT_W = $clog2(MAX_TARGETS + 1);

   // scan state
   logic                          active_ff, active_in;
   logic                          dwelling_ff, dwelling_in;
   logic [sss_pkg::TIME_W-1:0]    dwell_start_ff, dwell_start_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              done_cnt_ff, done_cnt_in;
   logic [sss_pkg::RING_W-1:0]    ring_ff, ring_in;
   logic [sss_pkg::RING_W-1:0]    last_ff, last_in;
   logic [sss_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [sss_pkg::POS_W-1:0]     size_ff, size_in;
   logic                          snake_ff, snake_in;
   logic signed [sss_pkg::AZ_W-1:0] az_ff, az_in;
   logic [sss_pkg::EL_W-1:0]      el_ff, el_in;
   logic [sss_pkg::STEP_W-1:0]    step_ff, step_in;

   // result register
   logic                          ovalid_ff, ovalid_in;
   logic [sss_pkg::EVENT_W-1:0]   oev_ff;
   logic signed [sss_pkg::AZ_W-1:0] oaz_ff;
   logic [sss_pkg::EL_W-1:0]      oel_ff;
   logic [sss_pkg::IDX_W-1:0]     oidx_ff;

   // arithmetic
   logic [sss_pkg::STEP_W-1:0]        step_clamped;
   logic [sss_pkg::RING_W+sss_pkg::STEP_W-1:0] el_raw;
   logic                              el_top;
   logic [sss_pkg::EL_W-1:0]          ring_el;
   logic [26:0]                       size_num;
   logic [sss_pkg::POS_W-1:0]         n_eff;
   logic [sss_pkg::POS_W-1:0]         k_idx;
   logic                              back_half;
   logic [17:0]                       k360, n181;
   logic [18:0]                       k720, n359;
   logic                              clamp_hi;
   logic [sss_pkg::DVD_W-1:0]         div_dvd, q;
   logic [sss_pkg::DVS_W-1:0]         div_dvs;
   logic                              div_done;
   logic [sss_pkg::POS_W:0]           pos_next;

   // clamp step into its legal range
   always_comb begin
      if (step_cfg < sss_pkg::STEP_MIN) begin
         step_clamped = sss_pkg::STEP_MIN;
      end else if (step_cfg > sss_pkg::STEP_MAX) begin
         step_clamped = sss_pkg::STEP_MAX;
      end else begin
         step_clamped = step_cfg;
      end
   end

   // ring elevation and ring-size numerator
   always_comb begin
      el_raw   = (sss_pkg::RING_W+sss_pkg::STEP_W)'(ring_ff) *
                 (sss_pkg::RING_W+sss_pkg::STEP_W)'(step_ff);
      el_top   = el_raw >= (sss_pkg::RING_W+sss_pkg::STEP_W)'(sss_pkg::EL_TOP);
      ring_el  = el_top ? sss_pkg::EL_W'(sss_pkg::EL_TOP) : el_raw[sss_pkg::EL_W-1:0];
      size_num = 27'(sss_pkg::cos_q16(ring_el)) * 27'(sss_pkg::SIZE_SCALE) +
                 (27'(step_ff) << 16);
   end

   // azimuth candidate: index within ring and the range checks
   always_comb begin
      n_eff     = (size_ff == '0) ? sss_pkg::POS_W'(1) : size_ff;
      k_idx     = snake_ff ? pos_ff : (n_eff - 1'b1 - pos_ff);
      back_half = {k_idx, 1'b0} >= {1'b0, n_eff};
      k360      = 18'(k_idx) * 18'd360;
      n181      = 18'(n_eff) * 18'd181;
      k720      = 19'(k_idx) * 19'd720;
      n359      = 19'(n_eff) * 19'd359;
      clamp_hi  = k720 >= n359;
      pos_next  = {1'b0, pos_ff} + 1'b1;
   end

   // divider operand select
   always_comb begin
      unique case (cmd.div_sel)
         sss_pkg::DIV_LAST: begin
            div_dvd = sss_pkg::DVD_W'(step_ff) + sss_pkg::DVD_W'(sss_pkg::LAST_BIAS);
            div_dvs = sss_pkg::DVS_W'(step_ff) << 1;
         end
         sss_pkg::DIV_SIZE: begin
            div_dvd = sss_pkg::DVD_W'(size_num[26:17]);
            div_dvs = sss_pkg::DVS_W'(step_ff);
         end
         sss_pkg::DIV_AZ: begin
            div_dvd = sss_pkg::DVD_W'(k_idx) * sss_pkg::DVD_W'(sss_pkg::AZ_SCALE) +
                      sss_pkg::DVD_W'(n_eff);
            div_dvs = {n_eff, 1'b0};
         end
         default: begin
            div_dvd = '0;
            div_dvs = sss_pkg::DVS_W'(1);
         end
      endcase
   end

   sss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (q),
      .done     (div_done)
   );

   // scan state next values
   always_comb begin
      active_in      = active_ff;
      dwelling_in    = dwelling_ff;
      dwell_start_in = dwell_start_ff;
      count_in       = count_ff;
      done_cnt_in    = done_cnt_ff;
      ring_in        = ring_ff;
      last_in        = last_ff;
      pos_in         = pos_ff;
      size_in        = size_ff;
      snake_in       = snake_ff;
      az_in          = az_ff;
      el_in          = el_ff;
      step_in        = step_ff;
      if (cmd.start_scan) begin
         step_in        = step_clamped;
         active_in      = 1'b1;
         dwelling_in    = 1'b0;
         dwell_start_in = '0;
         count_in       = '0;
         ring_in        = '0;
         pos_in         = '0;
         snake_in       = 1'b1;
         az_in          = '0;
         el_in          = '0;
      end
      if (cmd.finish) begin
         done_cnt_in    = count_ff;
         count_in       = '0;
         active_in      = 1'b0;
         dwelling_in    = 1'b0;
         dwell_start_in = '0;
      end
      if (cmd.arrive) begin
         dwelling_in    = 1'b1;
         dwell_start_in = time_ms;
      end
      if (cmd.count_inc) begin
         count_in       = count_ff + 1'b1;
         dwelling_in    = 1'b0;
         dwell_start_in = '0;
      end
      if (cmd.adv) begin
         if (pos_next >= {1'b0, size_ff}) begin
            ring_in  = ring_ff + 1'b1;
            snake_in = ~snake_ff;
            pos_in   = '0;
         end else begin
            pos_in = pos_next[sss_pkg::POS_W-1:0];
         end
      end
      if (cmd.last_ld) begin
         last_in = q[sss_pkg::RING_W-1:0];
      end
      if (cmd.size_ld) begin
         if (el_top || q[sss_pkg::POS_W-1:0] == '0) begin
            size_in = sss_pkg::POS_W'(1);
         end else begin
            size_in = q[sss_pkg::POS_W-1:0];
         end
      end
      if (cmd.az_ld) begin
         el_in = ring_el;
         if (back_half) begin
            az_in = sss_pkg::AZ_W'(q) - sss_pkg::AZ_W'(sss_pkg::AZ_WRAP);
         end else if (clamp_hi) begin
            az_in = sss_pkg::AZ_W'(sss_pkg::AZ_CLAMP);
         end else begin
            az_in = sss_pkg::AZ_W'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         dwelling_ff    <= 1'b0;
         dwell_start_ff <= '0;
         count_ff       <= '0;
         done_cnt_ff    <= '0;
         ring_ff        <= '0;
         last_ff        <= '0;
         pos_ff         <= '0;
         size_ff        <= '0;
         snake_ff       <= 1'b1;
         az_ff          <= '0;
         el_ff          <= '0;
         step_ff        <= sss_pkg::STEP_RESET;
      end else begin
         active_ff      <= active_in;
         dwelling_ff    <= dwelling_in;
         dwell_start_ff <= dwell_start_in;
         count_ff       <= count_in;
         done_cnt_ff    <= done_cnt_in;
         ring_ff        <= ring_in;
         last_ff        <= last_in;
         pos_ff         <= pos_in;
         size_ff        <= size_in;
         snake_ff       <= snake_in;
         az_ff          <= az_in;
         el_ff          <= el_in;
         step_ff        <= step_in;
      end
   end

   // result beat register
   always_comb begin
      ovalid_in = ovalid_ff & ~rsp_tready;
      if (cmd.emit) begin
         ovalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         oev_ff <= cmd.ev;
         if (cmd.ev == sss_pkg::EV_POINT || cmd.ev == sss_pkg::EV_ARRIVED) begin
            oaz_ff  <= az_ff;
            oel_ff  <= el_ff;
            oidx_ff <= sss_pkg::IDX_W'(count_ff);
         end else begin
            oaz_ff  <= '0;
            oel_ff  <= '0;
            oidx_ff <= sss_pkg::IDX_W'(done_cnt_ff);
         end
      end
   end

   assign rsp_tvalid      = ovalid_ff;
   assign event_res       = oev_ff;
   assign target_az_centi = oaz_ff;
   assign target_el       = oel_ff;
   assign target_index    = oidx_ff;

   // status back to the controller
   always_comb begin
      sts.active     = active_ff;
      sts.dwelling   = dwelling_ff;
      sts.req_start  = mode == sss_pkg::MODE_START;
      sts.req_stop   = mode == sss_pkg::MODE_STOP;
      sts.req_tick   = mode == sss_pkg::MODE_TICK;
      sts.moving     = rotator_moving;
      sts.expired    = (time_ms - dwell_start_ff) >= sss_pkg::TIME_W'(dwell_ms);
      sts.count_full = count_ff >= CNT_W'(MAX_TARGETS);
      sts.pos_wrap   = pos_next >= {1'b0, size_ff};
      sts.ring_over  = ring_ff > last_ff;
      sts.cand_skip  = back_half && (k360 <= n181);
      sts.div_done   = div_done;
      sts.out_free   = ~ovalid_ff | rsp_tready;
   end

endmodule

@@ rtl/core/sss_ctrl.sv @@
// sss_ctrl: sequencing state machine for the sky scan sequencer.
// Depends on sss_pkg for command/status structs and codes.

module sss_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sss_pkg::sts_type sts,
   output sss_pkg::cmd_type cmd
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b00000000001,
      ST_LAST_GO   = 11'b00000000010,
      ST_LAST_WAIT = 11'b00000000100,
      ST_SIZE_GO   = 11'b00000001000,
      ST_SIZE_WAIT = 11'b00000010000,
      ST_CNT_CHK   = 11'b00000100000,
      ST_ADV       = 11'b00001000000,
      ST_RING_CHK  = 11'b00010000000,
      ST_CAND      = 11'b00100000000,
      ST_AZ_WAIT   = 11'b01000000000,
      ST_EMIT      = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   sss_pkg::event_type ev_ff, ev_in;
   logic               accept;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in    = state_ff;
      ev_in       = ev_ff;
      cmd         = '0;
      cmd.ev      = ev_ff;
      cmd.div_sel = sss_pkg::DIV_LAST;
      unique case (state_ff)
         // decode an accepted beat
         ST_IDLE: begin
            if (accept) begin
               if (sts.req_start && !sts.active) begin
                  cmd.start_scan = 1'b1;
                  state_in       = ST_LAST_GO;
               end else if (sts.req_stop && sts.active) begin
                  cmd.finish = 1'b1;
                  ev_in      = sss_pkg::EV_STOPPED;
                  state_in   = ST_EMIT;
               end else if (sts.req_tick && sts.active && !sts.moving) begin
                  if (!sts.dwelling) begin
                     cmd.arrive = 1'b1;
                     ev_in      = sss_pkg::EV_ARRIVED;
                     state_in   = ST_EMIT;
                  end else if (sts.expired) begin
                     cmd.count_inc = 1'b1;
                     state_in      = ST_CNT_CHK;
                  end
               end
            end
         end
         // last ring index for the latched step
         ST_LAST_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = sss_pkg::DIV_LAST;
            state_in    = ST_LAST_WAIT;
         end
         ST_LAST_WAIT: begin
            if (sts.div_done) begin
               cmd.last_ld = 1'b1;
               state_in    = ST_SIZE_GO;
            end
         end
         // azimuth count of the current ring
         ST_SIZE_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = sss_pkg::DIV_SIZE;
            state_in    = ST_SIZE_WAIT;
         end
         ST_SIZE_WAIT: begin
            cmd.div_sel = sss_pkg::DIV_SIZE;
            if (sts.div_done) begin
               cmd.size_ld = 1'b1;
               state_in    = ST_CAND;
            end
         end
         ST_CNT_CHK: begin
            if (sts.count_full) begin
               cmd.finish = 1'b1;
               ev_in      = sss_pkg::EV_DONE;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_ADV;
            end
         end
         // step to the next grid position
         ST_ADV: begin
            cmd.adv  = 1'b1;
            state_in = sts.pos_wrap ? ST_RING_CHK : ST_CAND;
         end
         ST_RING_CHK: begin
            if (sts.ring_over) begin
               cmd.finish = 1'b1;
               ev_in      = sss_pkg::EV_DONE;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_SIZE_GO;
            end
         end
         // skip or compute the azimuth
         ST_CAND: begin
            if (sts.cand_skip) begin
               state_in = ST_ADV;
            end else begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = sss_pkg::DIV_AZ;
               state_in    = ST_AZ_WAIT;
            end
         end
         ST_AZ_WAIT: begin
            cmd.div_sel = sss_pkg::DIV_AZ;
            if (sts.div_done) begin
               cmd.az_ld = 1'b1;
               ev_in     = sss_pkg::EV_POINT;
               state_in  = ST_EMIT;
            end
         end
         // hand the result beat to the output register
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ev_ff    <= sss_pkg::EV_POINT;
      end else begin
         state_ff <= state_in;
         ev_ff    <= ev_in;
      end
   end

endmodule

@@ rtl/core/sss_checker.sv @@
// sss_checker: port-level checks of the sky scan sequencer, bound to top.
// Depends on sss_pkg for event codes and port widths.

module sss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [sss_pkg::EVENT_W-1:0]     rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // nothing pending out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // completion and stop carry no position
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sss_pkg::EV_DONE || rsp_tuser == sss_pkg::EV_STOPPED)
         |-> rsp_tdata[22:0] == 23'd0)
      else $error("end beat with nonzero position");

   // elevation never above zenith
   a_el_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:16] <= 7'd90)
      else $error("elevation out of range");

   // a fresh result follows an accepted beat
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready || !req_tvalid || $past(!req_tready))
      else $error("result appeared without work in flight");

endmodule

bind sky_scan_sequencer sss_checker u_sss_checker (.*);
